// File: design/cfsp_pkg.sv
package cfsp_pkg;

  localparam int COORD_BITS = 16;
  localparam int FRAC_BITS  = 14;
  localparam int DIR_BITS   = 16;
  localparam int MAG_BITS   = DIR_BITS;
  localparam int DVD_BITS   = MAG_BITS + FRAC_BITS + 1;
  localparam int SAT_BITS   = ((DVD_BITS > COORD_BITS) ? DVD_BITS : COORD_BITS) + 1;
  localparam int LATENCY    = DVD_BITS + 2;
  localparam int FACE_BITS  = 3;
  localparam int NUM_FACES  = 6;

  localparam logic [FACE_BITS-1:0] FACE_POS_X = 3'd0;
  localparam logic [FACE_BITS-1:0] FACE_NEG_X = 3'd1;
  localparam logic [FACE_BITS-1:0] FACE_POS_Y = 3'd2;
  localparam logic [FACE_BITS-1:0] FACE_NEG_Y = 3'd3;
  localparam logic [FACE_BITS-1:0] FACE_POS_Z = 3'd4;
  localparam logic [FACE_BITS-1:0] FACE_NEG_Z = 3'd5;

  localparam logic [1:0] AXIS_X = 2'd0;
  localparam logic [1:0] AXIS_Y = 2'd1;
  localparam logic [1:0] AXIS_Z = 2'd2;

  typedef struct packed {
    logic       neg;
    logic [1:0] axis;
  } src_t;

  typedef struct packed {
    src_t s;
    src_t t;
    src_t d;
  } route_t;

  typedef struct packed {
    logic [MAG_BITS-1:0] rem;
    logic [DVD_BITS-1:0] dq;
  } lane_t;

  typedef struct packed {
    logic                 vld;
    logic [FACE_BITS-1:0] face;
    logic                 ok;
    logic                 neg_s;
    logic                 neg_t;
    logic [MAG_BITS-1:0]  md;
    lane_t                s;
    lane_t                t;
  } stage_t;

  function automatic src_t mk_src(input logic neg, input logic [1:0] axis);
    src_t r;
    r.neg  = neg;
    r.axis = axis;
    return r;
  endfunction

  function automatic route_t face_route(input logic [FACE_BITS-1:0] f);
    route_t r;
    r.s = mk_src(1'b0, AXIS_X);
    r.t = mk_src(1'b0, AXIS_X);
    r.d = mk_src(1'b0, AXIS_X);
    case (f)
      FACE_POS_X: begin
        r.s = mk_src(1'b1, AXIS_Y);
        r.t = mk_src(1'b0, AXIS_Z);
        r.d = mk_src(1'b0, AXIS_X);
      end
      FACE_NEG_X: begin
        r.s = mk_src(1'b0, AXIS_Y);
        r.t = mk_src(1'b0, AXIS_Z);
        r.d = mk_src(1'b1, AXIS_X);
      end
      FACE_POS_Y: begin
        r.s = mk_src(1'b0, AXIS_X);
        r.t = mk_src(1'b0, AXIS_Z);
        r.d = mk_src(1'b0, AXIS_Y);
      end
      FACE_NEG_Y: begin
        r.s = mk_src(1'b1, AXIS_X);
        r.t = mk_src(1'b0, AXIS_Z);
        r.d = mk_src(1'b1, AXIS_Y);
      end
      FACE_POS_Z: begin
        r.s = mk_src(1'b1, AXIS_Y);
        r.t = mk_src(1'b1, AXIS_X);
        r.d = mk_src(1'b0, AXIS_Z);
      end
      FACE_NEG_Z: begin
        r.s = mk_src(1'b1, AXIS_Y);
        r.t = mk_src(1'b0, AXIS_X);
        r.d = mk_src(1'b1, AXIS_Z);
      end
      default: begin
        r.s = mk_src(1'b0, AXIS_X);
      end
    endcase
    return r;
  endfunction

endpackage

// File: design/cfsp_front.sv
module cfsp_front (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   start,
  input  logic                                   command,
  input  logic [cfsp_pkg::FACE_BITS-1:0]         face_in,
  input  logic signed [cfsp_pkg::DIR_BITS-1:0]   dir_x,
  input  logic signed [cfsp_pkg::DIR_BITS-1:0]   dir_y,
  input  logic signed [cfsp_pkg::DIR_BITS-1:0]   dir_z,
  output cfsp_pkg::stage_t                       dout
);
  import cfsp_pkg::*;

  logic signed [DIR_BITS-1:0] comp [3];
  logic [MAG_BITS-1:0]        mag [4];
  logic                       sgn [4];
  logic [FACE_BITS-1:0]       chosen;
  logic [FACE_BITS-1:0]       face_sel;
  logic                       face_ok;
  route_t                     rt;
  logic [MAG_BITS-1:0]        ms;
  logic [MAG_BITS-1:0]        mt;
  logic                       d_sgn;
  logic                       s_sgn;
  logic                       t_sgn;
  stage_t                     dout_next;

  always_comb begin
    comp[0] = dir_x;
    comp[1] = dir_y;
    comp[2] = dir_z;
    for (int i = 0; i < 3; i++) begin
      sgn[i] = comp[i][DIR_BITS-1];
      mag[i] = comp[i][DIR_BITS-1] ? MAG_BITS'(-comp[i]) : MAG_BITS'(comp[i]);
    end
    mag[3] = '0;
    sgn[3] = 1'b0;

    if (mag[0] > mag[1] && mag[0] > mag[2]) begin
      chosen = sgn[0] ? FACE_NEG_X : FACE_POS_X;
    end else if (mag[1] > mag[2] && mag[1] > mag[0]) begin
      chosen = sgn[1] ? FACE_NEG_Y : FACE_POS_Y;
    end else begin
      chosen = sgn[2] ? FACE_NEG_Z : FACE_POS_Z;
    end

    face_sel = command ? face_in : chosen;
    face_ok  = face_sel < FACE_BITS'(NUM_FACES);
    rt       = face_route(face_sel);

    ms    = mag[rt.s.axis];
    mt    = mag[rt.t.axis];
    s_sgn = sgn[rt.s.axis] ^ rt.s.neg;
    t_sgn = sgn[rt.t.axis] ^ rt.t.neg;
    d_sgn = sgn[rt.d.axis] ^ rt.d.neg;

    dout_next.vld   = start && !rst;
    dout_next.face  = face_sel;
    dout_next.md    = mag[rt.d.axis];
    dout_next.ok    = face_ok && (mag[rt.d.axis] != '0);
    dout_next.neg_s = s_sgn ^ d_sgn;
    dout_next.neg_t = t_sgn ^ d_sgn;
    dout_next.s.rem = '0;
    dout_next.t.rem = '0;
    dout_next.s.dq  = DVD_BITS'({ms, {FRAC_BITS{1'b0}}})
                    + DVD_BITS'(mag[rt.d.axis] >> 1);
    dout_next.t.dq  = DVD_BITS'({mt, {FRAC_BITS{1'b0}}})
                    + DVD_BITS'(mag[rt.d.axis] >> 1);
  end

  always_ff @(posedge clk) begin
    dout <= dout_next;
  end

endmodule

// File: design/cfsp_div_cell.sv
module cfsp_div_cell (
  input  logic             clk,
  input  logic             rst,
  input  cfsp_pkg::stage_t din,
  output cfsp_pkg::stage_t dout
);
  import cfsp_pkg::*;

  stage_t dout_next;

  function automatic lane_t lane_step(input lane_t l, input logic [MAG_BITS-1:0] md);
    logic [MAG_BITS:0] shifted;
    logic [MAG_BITS:0] trial;
    logic              qbit;
    lane_t             r;
    shifted = {l.rem, l.dq[DVD_BITS-1]};
    trial   = shifted - {1'b0, md};
    qbit    = !trial[MAG_BITS];
    r.rem   = qbit ? trial[MAG_BITS-1:0] : shifted[MAG_BITS-1:0];
    r.dq    = {l.dq[DVD_BITS-2:0], qbit};
    return r;
  endfunction

  always_comb begin
    dout_next     = din;
    dout_next.vld = din.vld && !rst;
    dout_next.s   = lane_step(din.s, din.md);
    dout_next.t   = lane_step(din.t, din.md);
  end

  always_ff @(posedge clk) begin
    dout <= dout_next;
  end

endmodule

// File: design/cfsp_back.sv
module cfsp_back (
  input  logic                                 clk,
  input  logic                                 rst,
  input  cfsp_pkg::stage_t                     din,
  output logic                                 done,
  output logic [cfsp_pkg::FACE_BITS-1:0]       face,
  output logic signed [cfsp_pkg::COORD_BITS-1:0] s_coord,
  output logic signed [cfsp_pkg::COORD_BITS-1:0] t_coord,
  output logic                                 projected_ok,
  output logic                                 saturated
);
  import cfsp_pkg::*;

  typedef struct packed {
    logic                  sat;
    logic [COORD_BITS-1:0] v;
  } coord_res_t;

  localparam logic [SAT_BITS-1:0] LIM = SAT_BITS'(1) << (COORD_BITS - 1);

  coord_res_t rs;
  coord_res_t rt;

  function automatic coord_res_t clip(input logic [DVD_BITS-1:0] q, input logic neg);
    logic [SAT_BITS-1:0] qx;
    logic [SAT_BITS-1:0] qc;
    coord_res_t          r;
    qx    = {{(SAT_BITS-DVD_BITS){1'b0}}, q};
    r.sat = 1'b0;
    qc    = qx;
    if (neg) begin
      if (qx > LIM) begin
        qc    = LIM;
        r.sat = 1'b1;
      end
      qc = '0 - qc;
    end else begin
      if (qx > LIM - SAT_BITS'(1)) begin
        qc    = LIM - SAT_BITS'(1);
        r.sat = 1'b1;
      end
    end
    r.v = qc[COORD_BITS-1:0];
    return r;
  endfunction

  always_comb begin
    rs = clip(din.s.dq, din.neg_s);
    rt = clip(din.t.dq, din.neg_t);
  end

  always_ff @(posedge clk) begin
    face         <= din.face;
    projected_ok <= din.ok;
    s_coord      <= din.ok ? rs.v : '0;
    t_coord      <= din.ok ? rt.v : '0;
    saturated    <= din.ok && (rs.sat || rt.sat);
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= din.vld;
    end
  end

endmodule

// File: design/cubemap_face_select_project_unit.sv
// Cube map face selection and projection. One direction word is taken per
// cycle, every cycle (busy stays low), and its result is registered through
// the input stage, the divider cells and the output stage onto the ports,
// strobed by done for that one cycle; results leave in the order words
// arrived and the receiver cannot hold them off.
// The divider is a row of 31 restoring cells, one
// quotient bit per cell for s and t together, between an input stage that
// picks the face and operands and an output stage that signs and clips.
module cubemap_face_select_project_unit (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   start,
  output logic                                   busy,
  input  logic                                   command,
  input  logic [cfsp_pkg::FACE_BITS-1:0]         face_in,
  input  logic signed [cfsp_pkg::DIR_BITS-1:0]   dir_x,
  input  logic signed [cfsp_pkg::DIR_BITS-1:0]   dir_y,
  input  logic signed [cfsp_pkg::DIR_BITS-1:0]   dir_z,
  output logic                                   done,
  output logic [cfsp_pkg::FACE_BITS-1:0]         face,
  output logic signed [cfsp_pkg::COORD_BITS-1:0] s_coord,
  output logic signed [cfsp_pkg::COORD_BITS-1:0] t_coord,
  output logic                                   projected_ok,
  output logic                                   saturated
);
  import cfsp_pkg::*;

  stage_t chain [DVD_BITS+1];

  assign busy = 1'b0;

  cfsp_front u_front (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .command (command),
    .face_in (face_in),
    .dir_x   (dir_x),
    .dir_y   (dir_y),
    .dir_z   (dir_z),
    .dout    (chain[0])
  );

  for (genvar g = 0; g < DVD_BITS; g++) begin : g_cell
    cfsp_div_cell u_cell (
      .clk  (clk),
      .rst  (rst),
      .din  (chain[g]),
      .dout (chain[g+1])
    );
  end

  cfsp_back u_back (
    .clk          (clk),
    .rst          (rst),
    .din          (chain[DVD_BITS]),
    .done         (done),
    .face         (face),
    .s_coord      (s_coord),
    .t_coord      (t_coord),
    .projected_ok (projected_ok),
    .saturated    (saturated)
  );

  a_latency: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##LATENCY done)
    else $error("result strobe missing after fixed latency");

  a_degen_zero: assert property (@(posedge clk) disable iff (rst)
    (done && !projected_ok) |-> (s_coord == '0 && t_coord == '0 && !saturated))
    else $error("degenerate result carries coordinates");

  a_ok_face: assert property (@(posedge clk) disable iff (rst)
    (done && projected_ok) |-> (face < FACE_BITS'(NUM_FACES)))
    else $error("projection made on an invalid face");

  a_sat_ok: assert property (@(posedge clk) disable iff (rst)
    (done && saturated) |-> projected_ok)
    else $error("saturation flagged without a projection");

endmodule
